// File: hdl/flg_pkg.sv
package flg_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DELAY_DEPTH_DEF     = 2048;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;
  localparam int unsigned PHASE_BITS_DEF      = 16;
  localparam int unsigned DELAY_FRAC_BITS_DEF = 8;

  // Fixed register and table geometry
  localparam int unsigned DEPTH_W          = 10;
  localparam int unsigned PHASE_STEP_W     = 16;
  localparam int unsigned SINE_W           = 16;
  localparam int unsigned SINE_FRAC        = 15;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned MUL_B_W          = 18;
  localparam int unsigned PADDR_W          = 3;
  localparam int unsigned PDATA_W          = 32;

  localparam logic [DEPTH_W-1:0]      FLANGE_DEPTH_RST = 10'd200;
  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST   = 16'd0;

  typedef enum logic [0:0] {
    REG_FLANGE_DEPTH = 1'b0,
    REG_PHASE_STEP   = 1'b1
  } reg_idx_e;

  // Microprogram
  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_ACCEPT  = 4'd0;
  localparam pc_t PC_WRITE   = 4'd1;
  localparam pc_t PC_POS_L   = 4'd2;
  localparam pc_t PC_RD_LO_L = 4'd3;
  localparam pc_t PC_RD_HI_L = 4'd4;
  localparam pc_t PC_MUL_L   = 4'd5;
  localparam pc_t PC_RES_L   = 4'd6;
  localparam pc_t PC_POS_R   = 4'd7;
  localparam pc_t PC_RD_LO_R = 4'd8;
  localparam pc_t PC_RD_HI_R = 4'd9;
  localparam pc_t PC_MUL_R   = 4'd10;
  localparam pc_t PC_EMIT    = 4'd11;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_IN   = 2'd1,
    WAIT_OUT  = 2'd2
  } wait_e;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_LOW  = 2'd1,
    RD_HIGH = 2'd2
  } rd_e;

  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_BACK_L = 2'd1,
    MUL_BACK_R = 2'd2,
    MUL_INTERP = 2'd3
  } mul_e;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_LEFT = 2'd1,
    RES_EMIT = 2'd2
  } res_e;

  typedef struct packed {
    wait_e wait_sel;
    logic  accept;
    logic  mem_we;
    rd_e   rd_sel;
    mul_e  mul_sel;
    logic  pos_ld;
    logic  low_ld;
    res_e  res_sel;
    logic  jump;
    pc_t   jump_to;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    wait_sel: WAIT_NONE,
    accept:   1'b0,
    mem_we:   1'b0,
    rd_sel:   RD_NONE,
    mul_sel:  MUL_NONE,
    pos_ld:   1'b0,
    low_ld:   1'b0,
    res_sel:  RES_NONE,
    jump:     1'b0,
    jump_to:  PC_ACCEPT
  };

  // Control store: one word per step
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t c;
    c = CTRL_NOP;
    case (pc)
      PC_ACCEPT: begin
        c.wait_sel = WAIT_IN;
        c.accept   = 1'b1;
      end
      PC_WRITE: begin
        c.mem_we  = 1'b1;
        c.mul_sel = MUL_BACK_L;
      end
      PC_POS_L:   c.pos_ld = 1'b1;
      PC_RD_LO_L: c.rd_sel = RD_LOW;
      PC_RD_HI_L: begin
        c.low_ld = 1'b1;
        c.rd_sel = RD_HIGH;
      end
      PC_MUL_L:   c.mul_sel = MUL_INTERP;
      PC_RES_L: begin
        c.res_sel = RES_LEFT;
        c.mul_sel = MUL_BACK_R;
      end
      PC_POS_R:   c.pos_ld = 1'b1;
      PC_RD_LO_R: c.rd_sel = RD_LOW;
      PC_RD_HI_R: begin
        c.low_ld = 1'b1;
        c.rd_sel = RD_HIGH;
      end
      PC_MUL_R:   c.mul_sel = MUL_INTERP;
      PC_EMIT: begin
        c.wait_sel = WAIT_OUT;
        c.res_sel  = RES_EMIT;
        c.jump     = 1'b1;
        c.jump_to  = PC_ACCEPT;
      end
      default: begin
        c.jump    = 1'b1;
        c.jump_to = PC_ACCEPT;
      end
    endcase
    return c;
  endfunction

  // Sine table, built at elaboration
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef logic [SINE_TABLE_DEPTH-1:0][SINE_W-1:0] sine_rom_t;

  function automatic longint unsigned quarter_sine_q30(longint unsigned f);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (f * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    return longint'(sum);
  endfunction

  function automatic logic [SINE_W-1:0] sine_entry(int unsigned i);
    longint unsigned t;
    longint unsigned f;
    longint unsigned s;
    longint unsigned q15;
    logic [1:0]      quad;
    t    = (longint'(i) << 32) / SINE_TABLE_DEPTH;
    quad = 2'(t >> 30);
    f    = t & (ONE_Q30 - 64'd1);
    if (quad[0]) begin
      f = ONE_Q30 - f;
    end
    s   = quarter_sine_q30(f);
    q15 = (s + 64'd16384) >> 15;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return quad[1] ? SINE_W'(-q15) : SINE_W'(q15);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

endpackage

// File: hdl/flg_if.sv
interface flg_in_if #(
  parameter int unsigned SAMPLE_BITS = flg_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] dry_sample;

  modport source(output valid, output dry_sample, input ready);
  modport sink(input valid, input dry_sample, output ready);
endinterface

interface flg_out_if #(
  parameter int unsigned SAMPLE_BITS = flg_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source(output valid, output left_sample, output right_sample, input ready);
  modport sink(input valid, input left_sample, input right_sample, output ready);
endinterface

// File: hdl/flg_seq.sv
module flg_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_busy_i,
  output flg_pkg::ctrl_t      ctrl_o,
  output logic                fire_o,
  output logic                in_ready_o
);

  flg_pkg::pc_t   pc_q, pc_d;
  flg_pkg::ctrl_t ctrl;

  assign ctrl   = flg_pkg::ucode(pc_q);
  assign ctrl_o = ctrl;

  // A step with a wait condition holds until the condition is met
  always_comb begin
    case (ctrl.wait_sel)
      flg_pkg::WAIT_IN:  fire_o = in_valid_i;
      flg_pkg::WAIT_OUT: fire_o = !out_busy_i;
      default:           fire_o = 1'b1;
    endcase
  end

  assign in_ready_o = (ctrl.wait_sel == flg_pkg::WAIT_IN);

  always_comb begin
    if (!fire_o) begin
      pc_d = pc_q;
    end else if (ctrl.jump) begin
      pc_d = ctrl.jump_to;
    end else begin
      pc_d = pc_q + flg_pkg::pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= flg_pkg::PC_ACCEPT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: hdl/flg_dp.sv
module flg_dp #(
  parameter int unsigned DELAY_DEPTH     = flg_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS     = flg_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned PHASE_BITS      = flg_pkg::PHASE_BITS_DEF,
  parameter int unsigned DELAY_FRAC_BITS = flg_pkg::DELAY_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  flg_pkg::ctrl_t                         ctrl_i,
  input  logic                                   fire_i,
  input  logic signed [SAMPLE_BITS-1:0]          dry_sample_i,
  input  logic [flg_pkg::DEPTH_W-1:0]            flange_depth_i,
  input  logic [flg_pkg::PHASE_STEP_W-1:0]       lfo_phase_step_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]          left_o,
  output logic signed [SAMPLE_BITS-1:0]          right_o,
  output logic                                   out_busy_o
);

  localparam int unsigned AW     = $clog2(DELAY_DEPTH);
  localparam int unsigned FW     = DELAY_FRAC_BITS;
  localparam int unsigned FILL_W = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned SIW    = flg_pkg::SINE_IDX_W;
  localparam int unsigned MA     = (SAMPLE_BITS + 1 > flg_pkg::DEPTH_W + 1) ?
                                   SAMPLE_BITS + 1 : flg_pkg::DEPTH_W + 1;
  localparam int unsigned MB     = flg_pkg::MUL_B_W;
  localparam int unsigned PRW    = MA + MB;
  localparam int unsigned SPW    = FILL_W + FW;
  localparam int unsigned CW     = (PRW > SPW + 1) ? PRW : SPW + 1;
  localparam int unsigned LW     = PRW + 1;
  localparam int unsigned SHIFT  = flg_pkg::SINE_FRAC - FW;

  localparam flg_pkg::sine_rom_t    SineRom = flg_pkg::build_sine_rom();
  localparam logic [CW-1:0]         Span    = CW'(DELAY_DEPTH) << FW;
  localparam logic signed [MB-1:0]  OneQ15  = MB'(32768);
  localparam logic signed [LW-1:0]  Half    = LW'(2 ** (FW - 1));
  localparam logic [AW-1:0]         LastIdx = AW'(DELAY_DEPTH - 1);
  localparam logic [FILL_W-1:0]     Full    = FILL_W'(DELAY_DEPTH);

  logic signed [SAMPLE_BITS-1:0] delay_line_q [DELAY_DEPTH];

  logic [AW-1:0]                 wp_q, wp_d;
  logic [FILL_W-1:0]             fill_q, fill_d;
  logic [PHASE_BITS-1:0]         phase_q, phase_d;
  logic signed [flg_pkg::SINE_W-1:0] sine_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [PRW-1:0]         prod_q, prod_d;
  logic [AW+FW-1:0]              pos_q, pos_d;
  logic signed [SAMPLE_BITS-1:0] low_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic                          rvalid_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;

  logic                          do_accept, do_we, do_re, do_mul, do_pos, do_low;
  logic                          do_left, do_emit;
  logic [PHASE_BITS+SIW-1:0]     phase_sc;
  logic [SIW-1:0]                sine_idx;
  logic [AW-1:0]                 ip, ip1, mem_addr;
  logic [FW-1:0]                 frac;
  logic                          entry_valid;
  logic signed [SAMPLE_BITS-1:0] rd_val;
  logic signed [MA-1:0]          mul_a;
  logic signed [MB-1:0]          mul_b;
  logic [CW-1:0]                 back_raw, back_sat, pos_sum, pos_wrap;
  logic signed [LW-1:0]          lin, lin_sh;
  logic signed [SAMPLE_BITS-1:0] interp;

  assign do_accept = fire_i & ctrl_i.accept;
  assign do_we     = fire_i & ctrl_i.mem_we;
  assign do_re     = fire_i & (ctrl_i.rd_sel != flg_pkg::RD_NONE);
  assign do_mul    = fire_i & (ctrl_i.mul_sel != flg_pkg::MUL_NONE);
  assign do_pos    = fire_i & ctrl_i.pos_ld;
  assign do_low    = fire_i & ctrl_i.low_ld;
  assign do_left   = fire_i & (ctrl_i.res_sel == flg_pkg::RES_LEFT);
  assign do_emit   = fire_i & (ctrl_i.res_sel == flg_pkg::RES_EMIT);

  // Table index: top bits of the phase scaled by the table size
  assign phase_sc = {phase_q, {SIW{1'b0}}};
  assign sine_idx = phase_sc[PHASE_BITS+SIW-1:PHASE_BITS];

  assign wp_d    = (wp_q == LastIdx) ? '0 : wp_q + AW'(1);
  assign fill_d  = (fill_q == Full) ? fill_q : fill_q + FILL_W'(1);
  assign phase_d = phase_q + PHASE_BITS'(lfo_phase_step_i);

  // Read address from the fractional position
  assign ip   = pos_q[AW+FW-1:FW];
  assign frac = pos_q[FW-1:0];
  assign ip1  = (ip == LastIdx) ? '0 : ip + AW'(1);

  always_comb begin
    case (ctrl_i.rd_sel)
      flg_pkg::RD_LOW:  mem_addr = ip;
      flg_pkg::RD_HIGH: mem_addr = ip1;
      default:          mem_addr = wp_q;
    endcase
  end

  // Entries are written in order from index one, so the fill count tells
  // which ones hold data; the rest read as zero.
  assign entry_valid = (fill_q == Full) ||
                       ((mem_addr != '0) && (FILL_W'(mem_addr) <= fill_q));
  assign rd_val      = rvalid_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (do_we) begin
      delay_line_q[mem_addr] <= sample_q;
    end
    if (do_re) begin
      rdata_q <= delay_line_q[mem_addr];
    end
  end

  // Shared multiplier
  always_comb begin
    case (ctrl_i.mul_sel)
      flg_pkg::MUL_BACK_L: begin
        mul_a = MA'($signed({1'b0, flange_depth_i}));
        mul_b = OneQ15 + MB'(sine_q);
      end
      flg_pkg::MUL_BACK_R: begin
        mul_a = MA'($signed({1'b0, flange_depth_i}));
        mul_b = OneQ15 - MB'(sine_q);
      end
      flg_pkg::MUL_INTERP: begin
        mul_a = MA'(rd_val) - MA'(low_q);
        mul_b = MB'($signed({1'b0, frac}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Delay to read position, saturated and wrapped into the line
  assign back_raw = CW'($unsigned(prod_q) >> SHIFT);
  assign back_sat = (back_raw > Span) ? Span : back_raw;
  assign pos_sum  = (CW'(wp_q) << FW) + Span - back_sat;
  assign pos_wrap = (pos_sum >= Span) ? pos_sum - Span : pos_sum;
  assign pos_d    = pos_wrap[AW+FW-1:0];

  // Linear interpolation, rounded half up
  assign lin    = (LW'(low_q) <<< FW) + LW'(prod_q) + Half;
  assign lin_sh = lin >>> FW;
  assign interp = lin_sh[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (do_accept) begin
      sample_q <= dry_sample_i;
      sine_q   <= $signed(SineRom[sine_idx]);
    end
    if (do_mul) begin
      prod_q <= prod_d;
    end
    if (do_pos) begin
      pos_q <= pos_d;
    end
    if (do_low) begin
      low_q <= rd_val;
    end
    if (do_left) begin
      left_q <= interp;
    end
    if (do_emit) begin
      out_left_q  <= left_q;
      out_right_q <= interp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      phase_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_accept) begin
        wp_q <= wp_d;
      end
      if (do_we) begin
        fill_q <= fill_d;
      end
      if (do_re) begin
        rvalid_q <= entry_valid;
      end
      if (do_emit) begin
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_o      = out_left_q;
  assign right_o     = out_right_q;
  assign out_busy_o  = out_valid_q & ~out_ready_i;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Full)
    else $error("fill count past line depth");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_we || do_re) |-> ({1'b0, mem_addr} < (AW + 1)'(DELAY_DEPTH)))
    else $error("delay line address out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_emit |-> !(out_valid_q && !out_ready_i))
    else $error("result loaded over a waiting result");

  a_write_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_accept |=> (ctrl_i.mem_we && fire_i))
    else $error("accepted sample not written next cycle");

endmodule

// File: hdl/stereo_flanger_delay.sv
// Stereo flanger on an interpolated delay line.
//
// Input channel dry_i carries one signed mono sample per request. Output
// channel wet_o returns one request per input with the left and right
// samples, each linearly interpolated from the delay line at a delay of
// depth*(1+s) and depth*(1-s) samples, s being a table sine LFO. Both
// channels use a valid/ready handshake. An APB-style port sets the center
// depth (offset 0) and LFO phase step (offset 4); the user must write them
// only while idle, which the block itself does not enforce.
// A twelve-step microprogram runs each sample through one shared multiplier
// and one single-port delay-line memory (one write, four reads). A new
// sample is taken only once all steps for the last one have run, and the
// final step waits while the receiver holds an earlier result; the memory
// port and the shared multiplier set the number of steps.
//
// After reset the delay line reads as zero: a fill count marks which
// entries have been written, so there is no clearing pass and dry_i is
// ready at once. A stalled receiver keeps its result in the output
// register; one more sample is taken and processed meanwhile, and the
// sequencer holds at its final step until the register drains.
module stereo_flanger_delay #(
  parameter int unsigned DELAY_DEPTH     = flg_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS     = flg_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned PHASE_BITS      = flg_pkg::PHASE_BITS_DEF,
  parameter int unsigned DELAY_FRAC_BITS = flg_pkg::DELAY_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  flg_in_if.sink                        dry_i,
  flg_out_if.source                     wet_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flg_pkg::PADDR_W-1:0]   paddr,
  input  logic [flg_pkg::PDATA_W-1:0]   pwdata,
  output logic [flg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [flg_pkg::DEPTH_W-1:0]      flange_depth_q;
  logic [flg_pkg::PHASE_STEP_W-1:0] lfo_phase_step_q;
  flg_pkg::reg_idx_e                reg_idx;
  logic                             cfg_write;

  flg_pkg::ctrl_t ctrl;
  logic           fire;
  logic           out_busy;

  // Register file: word-aligned, byte offset bits ignored
  assign reg_idx   = flg_pkg::reg_idx_e'(paddr[flg_pkg::PADDR_W-1:2]);
  assign cfg_write = psel & penable & pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flange_depth_q   <= flg_pkg::FLANGE_DEPTH_RST;
      lfo_phase_step_q <= flg_pkg::PHASE_STEP_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        flg_pkg::REG_FLANGE_DEPTH: flange_depth_q   <= pwdata[flg_pkg::DEPTH_W-1:0];
        flg_pkg::REG_PHASE_STEP:   lfo_phase_step_q <= pwdata[flg_pkg::PHASE_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back zero-extended
  always_comb begin
    case (reg_idx)
      flg_pkg::REG_FLANGE_DEPTH: prdata = flg_pkg::PDATA_W'(flange_depth_q);
      flg_pkg::REG_PHASE_STEP:   prdata = flg_pkg::PDATA_W'(lfo_phase_step_q);
      default:                   prdata = '0;
    endcase
  end

  // Step counter and control store: holds at the accept step until a
  // request arrives, and at the emit step while the output is occupied.
  flg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dry_i.valid),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl),
    .fire_o     (fire),
    .in_ready_o (dry_i.ready)
  );

  // Delay line, LFO, shared multiplier and output register
  flg_dp #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .DELAY_FRAC_BITS (DELAY_FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .fire_i           (fire),
    .dry_sample_i     (dry_i.dry_sample),
    .flange_depth_i   (flange_depth_q),
    .lfo_phase_step_i (lfo_phase_step_q),
    .out_ready_i      (wet_o.ready),
    .out_valid_o      (wet_o.valid),
    .left_o           (wet_o.left_sample),
    .right_o          (wet_o.right_sample),
    .out_busy_o       (out_busy)
  );

endmodule

// File: test/tb_stereo_flanger_delay.sv
module tb_stereo_flanger_delay;

  typedef logic signed [flg_pkg::SAMPLE_BITS_DEF-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_t;

  // Scoreboard: carries its own copy of the delay line, write pointer, LFO
  // phase and both registers, and turns each accepted dry sample into the
  // stereo pair the block must return.
  class flange_scoreboard;
    localparam int LINE_LEN = flg_pkg::DELAY_DEPTH_DEF;
    localparam int PTR_W    = $clog2(LINE_LEN);
    localparam int FRAC_W   = flg_pkg::DELAY_FRAC_BITS_DEF;
    localparam int PHASE_W  = flg_pkg::PHASE_BITS_DEF;
    localparam int TAB_LEN  = flg_pkg::SINE_TABLE_DEPTH;
    localparam longint unsigned SPAN     = 64'(LINE_LEN) << FRAC_W;
    localparam longint unsigned QTR_PI   = 64'd1686629713;
    localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
    localparam longint          MID      = 64'sd32768;

    sample_t                                line_mem[LINE_LEN];
    logic [PTR_W-1:0]                       wr_pos;
    logic [PHASE_W-1:0]                     lfo_phase;
    logic [flg_pkg::DEPTH_W-1:0]            depth;
    logic [flg_pkg::PHASE_STEP_W-1:0]       phase_step;
    int                                     sine_tab[TAB_LEN];
    stereo_t                                due_q[$];
    int                                     errors;

    function new();
      longint unsigned t;
      longint unsigned f;
      longint unsigned q;
      logic [1:0]      quad;
      for (int i = 0; i < TAB_LEN; i++) begin
        t    = (64'(i) << 32) / TAB_LEN;
        quad = 2'(t >> 30);
        f    = t & (UNIT_Q30 - 1);
        if (quad[0]) begin
          f = UNIT_Q30 - f;
        end
        q = (quarter_sine(f) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
          q = 64'd32767;
        end
        sine_tab[i] = quad[1] ? -int'(q) : int'(q);
      end
      foreach (line_mem[i]) line_mem[i] = '0;
      wr_pos     = '0;
      lfo_phase  = '0;
      depth      = flg_pkg::FLANGE_DEPTH_RST;
      phase_step = flg_pkg::PHASE_STEP_RST;
      errors     = 0;
    endfunction

    // sine over a quarter turn, Q30 in and out, odd-power series
    function longint unsigned quarter_sine(longint unsigned f);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x    = (f * QTR_PI) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      return longint'(acc);
    endfunction

    // fractional read 'back' delay units behind the write pointer
    function sample_t tap(longint unsigned back);
      longint unsigned pos;
      longint unsigned ip;
      longint unsigned ip1;
      longint unsigned frac;
      longint          acc;
      if (back > SPAN) begin
        back = SPAN;
      end
      pos  = ((64'(wr_pos) << FRAC_W) + SPAN - back) % SPAN;
      ip   = (pos >> FRAC_W) % LINE_LEN;
      ip1  = (ip + 1) % LINE_LEN;
      frac = pos & ((64'd1 << FRAC_W) - 1);
      acc  = longint'(line_mem[ip]) * longint'((64'd1 << FRAC_W) - frac)
           + longint'(line_mem[ip1]) * longint'(frac);
      // bias to non-negative so the shift rounds half up
      acc  = acc + (MID << FRAC_W) + (64'sd1 << (FRAC_W - 1));
      return sample_t'((acc >> FRAC_W) - MID);
    endfunction

    function void set_reg(flg_pkg::reg_idx_e r, logic [31:0] v);
      case (r)
        flg_pkg::REG_FLANGE_DEPTH: depth      = v[flg_pkg::DEPTH_W-1:0];
        flg_pkg::REG_PHASE_STEP:   phase_step = v[flg_pkg::PHASE_STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(flg_pkg::reg_idx_e r);
      return (r == flg_pkg::REG_FLANGE_DEPTH) ? 32'(depth) : 32'(phase_step);
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void take_dry(sample_t x);
      int              s;
      longint unsigned back_l;
      longint unsigned back_r;
      stereo_t         pair;
      wr_pos           = wr_pos + 1'b1;
      line_mem[wr_pos] = x;
      s      = sine_tab[(64'(lfo_phase) * TAB_LEN) >> PHASE_W];
      back_l = (64'(depth) * 64'(MID + s)) >> (15 - FRAC_W);
      back_r = (64'(depth) * 64'(MID - s)) >> (15 - FRAC_W);
      pair.left  = tap(back_l);
      pair.right = tap(back_r);
      lfo_phase  = lfo_phase + phase_step;
      due_q.push_back(pair);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_wet(sample_t l, sample_t r);
      stereo_t want;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("stray result left=%0d right=%0d", l, r));
        return;
      end
      want = due_q.pop_front();
      if (l !== want.left) begin
        report_mismatch($sformatf("left got %0d want %0d", l, $signed(want.left)));
      end
      if (r !== want.right) begin
        report_mismatch($sformatf("right got %0d want %0d", r, $signed(want.right)));
      end
    endtask
  endclass

  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 300;
  localparam int NUM_PHASES    = 6;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [flg_pkg::PADDR_W-1:0]     paddr;
  logic [flg_pkg::PDATA_W-1:0]     pwdata;
  logic [flg_pkg::PDATA_W-1:0]     prdata;
  logic                            pready;

  flg_in_if  dry_if ();
  flg_out_if wet_if ();

  flange_scoreboard sb;

  // idle odds in percent, and a long receiver hold-off request
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_req   = 0;

  stereo_flanger_delay dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dry_i   (dry_if),
    .wet_o   (wet_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample both handshakes at the rising edge: note accepted dry samples,
  // check accepted stereo results.
  always @(posedge clk_i) begin
    if (rst_ni && dry_if.valid && dry_if.ready) begin
      sb.take_dry(dry_if.dry_sample);
    end
    if (rst_ni && wet_if.valid && wet_if.ready) begin
      sb.check_wet(wet_if.left_sample, wet_if.right_sample);
    end
  end

  // Receiver: throttle ready at random, or hold it low for a counted stretch.
  initial begin : wet_sink
    int hold_left;
    hold_left    = 0;
    wet_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req != 0) begin
        hold_left = stall_req;
        stall_req = 0;
      end
      if (hold_left != 0) begin
        wet_if.ready <= 1'b0;
        hold_left--;
      end else begin
        wet_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one dry sample; enter and leave on a falling edge.
  task automatic send_dry(input sample_t x);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      dry_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    dry_if.valid      <= 1'b1;
    dry_if.dry_sample <= x;
    do @(posedge clk_i); while (!dry_if.ready);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every expected pair has come back.
  task automatic drain_wet();
    dry_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write a register, then read it back in the following transfer.
  task automatic program_reg(input flg_pkg::reg_idx_e r, input logic [31:0] v);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(r, v);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    if (got !== sb.reg_value(r)) begin
      sb.report_mismatch($sformatf("register %s reads %h want %h", r.name(), got,
                                   sb.reg_value(r)));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly full-range noise, some slow wander, some rail values.
  function automatic sample_t next_sample(sample_t prev);
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return sample_t'($urandom);
    end else if (pick < 90) begin
      return sample_t'(int'(prev) + int'($urandom_range(2048)) - 1024);
    end
    case ($urandom_range(3))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  initial begin : stimulus
    sample_t     warm_vals[$];
    sample_t     rail_vals[$];
    sample_t     quarter_vals[$];
    sample_t     prev;
    logic [31:0] cfg_depth[NUM_PHASES];
    logic [31:0] cfg_step[NUM_PHASES];

    sb                = new();
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    dry_if.valid      = 1'b0;
    dry_if.dry_sample = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: rails and patterns into a zeroed line.
    warm_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555};
    foreach (warm_vals[i]) send_dry(warm_vals[i]);
    drain_wet();

    // Zero depth reads the fresh sample; upper bus bits must be dropped.
    program_reg(flg_pkg::REG_FLANGE_DEPTH, 32'hFFFF_FC00);
    program_reg(flg_pkg::REG_PHASE_STEP, 32'hABCD_0000);
    rail_vals = '{16'shAAAA, 16'sh7FFF, 16'sh8000, 16'sh1234};
    foreach (rail_vals[i]) send_dry(rail_vals[i]);
    drain_wet();

    // Deepest delay with a phase step that wraps every sample.
    program_reg(flg_pkg::REG_FLANGE_DEPTH, 32'h0000_03FF);
    program_reg(flg_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    foreach (warm_vals[i]) send_dry(warm_vals[i]);
    drain_wet();

    // Quarter-turn steps, from the phase the last run left, land near the sine peaks and the zero crossings.
    program_reg(flg_pkg::REG_PHASE_STEP, 32'h0000_4000);
    quarter_vals = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                     16'sh0100, 16'shFF00, 16'sh7FFF, 16'sh8000};
    foreach (quarter_vals[i]) send_dry(quarter_vals[i]);
    drain_wet();

    cfg_depth = '{32'($urandom_range(1023)), 32'h3FF, 32'h0, $urandom, 32'h1, $urandom};
    cfg_step  = '{32'($urandom_range(1, 200)), 32'hFFFF, 32'h0, $urandom, 32'h8000,
                  $urandom};

    prev = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_reg(flg_pkg::REG_FLANGE_DEPTH, cfg_depth[p]);
      program_reg(flg_pkg::REG_PHASE_STEP, cfg_step[p]);
      case (p / 2)
        0: begin
          tx_idle_pct = 6;
          rx_idle_pct = 82;
        end
        1: begin
          tx_idle_pct = 82;
          rx_idle_pct = 6;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back up the output with a long receiver hold-off, keep offering
        if (p == 4 && n == PHASE_ITEMS / 3) begin
          stall_req = 400;
        end
        prev = next_sample(prev);
        send_dry(prev);
      end
      drain_wet();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("stereo_flanger_delay: match");
    end else begin
      $display("stereo_flanger_delay: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("stereo_flanger_delay: mismatch");
    $finish;
  end

endmodule
